// ===== hdl/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

  // Width of the per-string byte counter
  localparam int CNT_W = 16;
  // Width of the capacity register and of the reported byte count
  localparam int CAP_W = 16;
  localparam int BW_W  = 16;
  // Width that holds counter + char length and the limit without overflow
  localparam int SUM_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX = {{(SUM_W - CNT_W){1'b0}}, {CNT_W{1'b1}}};

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Surrogate ranges
  localparam logic [15:0] SURR_MIN     = 16'hD800;
  localparam logic [15:0] LOW_HALF_MIN = 16'hDC00;
  localparam logic [15:0] SURR_MAX     = 16'hDFFF;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT      = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'h3F;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            is_terminator;
    logic [BW_W-1:0] bytes_written;
  } out_item_t;

  // One queued transaction: up to four character bytes, then an optional NUL
  typedef struct packed {
    logic [3:0][7:0] char_bytes;
    logic [2:0]      nbytes;
    logic            term;
    logic [BW_W-1:0] count;
  } cmd_t;

endpackage

// ===== hdl/utt_front.sv =====
// ----------------------------------------------------------------------------
// utt_front
// Accepts code units, pairs surrogates, checks capacity and encodes each
// character into a byte command for the back end.
// ----------------------------------------------------------------------------
module utt_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  utt_pkg::in_item_t        in_data,
  input  logic [utt_pkg::CAP_W-1:0] cap,
  input  logic                     q_full,
  output logic                     push,
  output utt_pkg::cmd_t            cmd
);
  import utt_pkg::*;

  logic [15:0]      held_r, held_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic [CNT_W-1:0] wc_r, wc_nxt;
  logic             done_r, done_nxt;

  logic             acc;
  logic [15:0]      unit;
  logic             fin;
  logic [15:0]      hi, lo;
  logic [20:0]      cp;
  logic [2:0]       len;
  logic [3:0][7:0]  enc;
  logic [CAP_W-1:0] lim16;
  logic [SUM_W-1:0] lim;
  logic [SUM_W-1:0] sum;

  assign acc  = in_valid && !q_full;
  assign unit = in_data.code_unit;
  assign fin  = in_data.final_unit;

  // Held half decides the order of the pair
  always_comb begin
    if (held_r >= LOW_HALF_MIN) begin
      hi = unit;
      lo = held_r;
    end else begin
      hi = held_r;
      lo = unit;
    end
  end

  always_comb begin
    if (held_valid_r) begin
      cp = 21'h10000 + 21'({hi[9:0], 10'b0}) + 21'(lo[9:0]);
    end else begin
      cp = 21'(unit);
    end
  end

  always_comb begin
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < 21'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
  end

  always_comb begin
    enc = '0;
    case (len)
      3'd1: begin
        enc[0] = cp[7:0];
      end
      3'd2: begin
        enc[0] = LEAD2 | {3'b0, cp[10:6]};
        enc[1] = CONT | ({2'b0, cp[5:0]} & CONT_MASK);
      end
      3'd3: begin
        enc[0] = LEAD3 | {4'b0, cp[15:12]};
        enc[1] = CONT | {2'b0, cp[11:6]};
        enc[2] = CONT | {2'b0, cp[5:0]};
      end
      default: begin
        enc[0] = LEAD4 | {5'b0, cp[20:18]};
        enc[1] = CONT | {2'b0, cp[17:12]};
        enc[2] = CONT | {2'b0, cp[11:6]};
        enc[3] = CONT | {2'b0, cp[5:0]};
      end
    endcase
  end

  // Byte limit: capacity minus the NUL, clamped to the counter range
  assign lim16 = (cap == '0) ? '0 : cap - 1'b1;
  assign lim   = (SUM_W'(lim16) > CNT_MAX) ? CNT_MAX : SUM_W'(lim16);
  assign sum   = SUM_W'(wc_r) + SUM_W'(len);

  always_comb begin
    logic has_char;
    logic ends;
    logic [SUM_W-1:0] cnt_ext;
    has_char       = 1'b0;
    ends           = fin;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    wc_nxt         = wc_r;
    done_nxt       = done_r;
    push           = 1'b0;
    cmd            = '0;
    cnt_ext        = '0;
    if (acc) begin
      if (done_r) begin
        if (fin) begin
          done_nxt = 1'b0;
          wc_nxt   = '0;
        end
      end else begin
        if (held_valid_r) begin
          has_char       = 1'b1;
          held_valid_nxt = 1'b0;
          held_nxt       = '0;
        end else if (unit == '0) begin
          ends = 1'b1;
        end else if (unit >= SURR_MIN && unit <= SURR_MAX) begin
          if (!fin) begin
            held_nxt       = unit;
            held_valid_nxt = 1'b1;
          end
        end else begin
          has_char = 1'b1;
        end

        if (has_char) begin
          if (sum <= lim) begin
            cmd.char_bytes = enc;
            cmd.nbytes     = len;
            wc_nxt         = sum[CNT_W-1:0];
          end else begin
            ends = 1'b1;
          end
        end

        if (ends) begin
          cnt_ext   = SUM_W'(wc_nxt);
          cmd.term  = 1'b1;
          cmd.count = cnt_ext[BW_W-1:0];
          held_nxt       = '0;
          held_valid_nxt = 1'b0;
          if (fin) begin
            wc_nxt   = '0;
            done_nxt = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end
        push = (cmd.nbytes != '0) || cmd.term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
      wc_r         <= '0;
      done_r       <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      wc_r         <= wc_nxt;
      done_r       <= done_nxt;
    end
  end

  a_held_is_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (held_r >= SURR_MIN && held_r <= SURR_MAX))
    else $error("held unit is not a surrogate");

  a_done_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !held_valid_r)
    else $error("surrogate held after string end");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cmd.nbytes <= 3'd4 && !q_full))
    else $error("bad command pushed");

endmodule

// ===== hdl/utt_queue.sv =====
// ----------------------------------------------------------------------------
// utt_queue
// Small FIFO of byte commands between the front and back ends.
// ----------------------------------------------------------------------------
module utt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utt_pkg::cmd_t wr_data,
  input  logic          pop,
  output utt_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import utt_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== hdl/utt_back.sv =====
// ----------------------------------------------------------------------------
// utt_back
// Walks one command at a time and sends its bytes, then its NUL if it has
// one, one per cycle through the output register unless the output stalls.
// ----------------------------------------------------------------------------
module utt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  utt_pkg::cmd_t      q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output utt_pkg::out_item_t out_data
);
  import utt_pkg::*;

  cmd_t      cur_r;
  logic      cur_valid_r;
  logic [2:0] idx_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic       adv;
  logic [2:0] total;
  logic       last;
  out_item_t  item;

  assign adv   = !out_valid_r || !out_stall;
  assign total = cur_r.nbytes + {2'b0, cur_r.term};
  assign last  = cur_valid_r && adv && (idx_r == total - 1'b1);
  assign pop   = !q_empty && (!cur_valid_r || last);

  always_comb begin
    item = '0;
    if (idx_r < cur_r.nbytes) begin
      item.out_byte = cur_r.char_bytes[idx_r[1:0]];
    end else begin
      item.is_terminator = 1'b1;
      item.bytes_written = cur_r.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= cur_valid_r;
      end
      if (pop) begin
        idx_r <= '0;
      end else if (adv && cur_valid_r) begin
        idx_r <= idx_r + 1'b1;
      end
      if (pop) begin
        cur_valid_r <= 1'b1;
      end else if (last) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data;
    end
    if (adv && cur_valid_r) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < total))
    else $error("byte index past end of command");

  a_cmd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (total != 3'd0))
    else $error("empty command in the back end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled output changed");

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streaming UTF-16 to UTF-8 converter with capacity limit and NUL terminator.
// ----------------------------------------------------------------------------
// One code unit is taken per cycle, while the four-entry command queue has
// room; the output side sends one UTF-8 byte per cycle unless the receiver
// stalls, so the sustained cost of a unit is set by the byte-serial output
// register: one byte for ASCII, two or three for other basic-plane characters,
// four for a surrogate pair (spread over its two units), plus the NUL when a
// string ends. A held surrogate or a dropped unit costs nothing on the output
// side. The first byte of a unit passes through the command queue, the back
// end's command register and the output register before it is presented.
// The string ends on a zero unit, on the unit flagged final, or when the
// next character would not fit in cfg capacity minus one bytes; the NUL then
// carries the count of bytes sent, and units up to the final one are dropped.
// Write the capacity only while the block is idle.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  utt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output utt_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [utt_pkg::CAP_W-1:0] cfg_wr_data
);
  import utt_pkg::*;

  // Destination size in bytes, NUL included
  logic [CAP_W-1:0] cap_r;

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Hold the input while the queue has no free entry
  assign in_stall = q_full;

  // Front: pair surrogates, check capacity, encode a whole character
  utt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cap      (cap_r),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue: decouple unit acceptance from byte output
  utt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (pop_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: serialize bytes and the terminator into the output register
  utt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/utf8_byte_predictor_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_predictor_pkg
// Predicts the UTF-8 byte stream of the transcoder and checks the actual one.
// ----------------------------------------------------------------------------
package utf8_byte_predictor_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  class utf8_byte_predictor;
    logic [CAP_W-1:0] capacity;
    logic [15:0]      held_unit;
    bit               held;
    int unsigned      byte_count;
    bit               ended;
    out_item_t        expected_bytes[$];
    int               errors;

    function new();
      capacity = CAP_RESET;
      errors   = 0;
      clear_string();
    endfunction

    function void clear_string();
      held_unit  = '0;
      held       = 1'b0;
      byte_count = 0;
      ended      = 1'b0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b, bit term, logic [BW_W-1:0] cnt);
      out_item_t r;
      r.out_byte      = b;
      r.is_terminator = term;
      r.bytes_written = cnt;
      expected_bytes.push_back(r);
    endfunction

    // Queue the bytes of one character; return 0 when it does not fit.
    function bit put_char(logic [20:0] cp);
      int unsigned len;
      int unsigned limit_bytes;
      len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      limit_bytes = (capacity == '0) ? 0 : int'(capacity) - 1;
      if (byte_count + len > limit_bytes) return 1'b0;
      case (len)
        1: begin
          push_byte(8'(cp), 1'b0, '0);
        end
        2: begin
          push_byte(LEAD2 | 8'(cp >> 6), 1'b0, '0);
          push_byte(CONT | (8'(cp) & CONT_MASK), 1'b0, '0);
        end
        3: begin
          push_byte(LEAD3 | 8'(cp >> 12), 1'b0, '0);
          push_byte(CONT | (8'(cp >> 6) & CONT_MASK), 1'b0, '0);
          push_byte(CONT | (8'(cp) & CONT_MASK), 1'b0, '0);
        end
        default: begin
          push_byte(LEAD4 | 8'(cp >> 18), 1'b0, '0);
          push_byte(CONT | (8'(cp >> 12) & CONT_MASK), 1'b0, '0);
          push_byte(CONT | (8'(cp >> 6) & CONT_MASK), 1'b0, '0);
          push_byte(CONT | (8'(cp) & CONT_MASK), 1'b0, '0);
        end
      endcase
      byte_count = (byte_count + len) & 32'hFFFF;
      return 1'b1;
    endfunction

    // Note one accepted input transaction and queue the bytes it causes.
    function void note_unit(in_item_t it);
      logic [15:0] unit;
      logic [15:0] hi;
      logic [15:0] lo;
      bit          fin;
      bit          stop;
      unit = it.code_unit;
      fin  = it.final_unit;
      stop = fin;
      if (ended) begin
        if (fin) clear_string();
        return;
      end
      if (held) begin
        // The half that was held decides the order of the pair.
        if (held_unit >= LOW_HALF_MIN) begin
          lo = held_unit;
          hi = unit;
        end else begin
          hi = held_unit;
          lo = unit;
        end
        held      = 1'b0;
        held_unit = '0;
        if (!put_char(21'h10000 + {1'b0, hi[9:0], lo[9:0]})) stop = 1'b1;
      end else if (unit == '0) begin
        stop = 1'b1;
      end else if (unit >= SURR_MIN && unit <= SURR_MAX) begin
        if (!fin) begin
          held_unit = unit;
          held      = 1'b1;
        end
      end else if (!put_char({5'd0, unit})) begin
        stop = 1'b1;
      end
      if (stop) begin
        push_byte(8'h00, 1'b1, BW_W'(byte_count));
        if (fin) begin
          clear_string();
        end else begin
          held_unit = '0;
          held      = 1'b0;
          ended     = 1'b1;
        end
      end
    endfunction

    // Compare one accepted output transaction with the oldest expectation.
    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h/%b/%0d", $time,
                 got.out_byte, got.is_terminator, got.bytes_written);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time,
                 want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_terminator !== want.is_terminator) begin
        $display("%0t: is_terminator expected %b actual %b", $time,
                 want.is_terminator, got.is_terminator);
        errors++;
      end
      if (got.bytes_written !== want.bytes_written) begin
        $display("%0t: bytes_written expected %0d actual %0d", $time,
                 want.bytes_written, got.bytes_written);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Self-checking bench: streams UTF-16 units through the transcoder under
// several capacity settings and checks every UTF-8 byte and terminator.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;

  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;
  import utf8_byte_predictor_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  // Cycles to let queued no-result transactions flush before a config write
  localparam int SETTLE       = 16;
  localparam int PHASE_UNITS  = 45;
  localparam int LONG_HOLD    = 300;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  utf8_byte_predictor predictor;
  in_item_t           stim_units[$];
  int                 burst_left;
  bit                 hold_req;
  int                 cycle_count;

  utf16_to_utf8_transcoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the stream never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Check every byte the block hands over; values are sampled before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      predictor.check_byte(out_data);
    end
  end

  // Receiver: stall on random patterns of random density, with stretches of
  // no stall at all, and hold off for a long stretch when asked.
  initial begin
    int unsigned density;
    int unsigned seg_len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        density = $urandom_range(0, 3);
        seg_len = $urandom_range(5, 40);
        repeat (seg_len) begin
          out_stall <= ($urandom_range(0, 3) < density);
          @(posedge clk);
        end
      end
    end
  end

  function automatic void queue_unit(logic [15:0] code, bit fin);
    in_item_t u;
    u.code_unit  = code;
    u.final_unit = fin;
    stim_units.push_back(u);
  endfunction

  // Build one string of mostly well-formed characters with some noise; the
  // last unit carries the final flag.
  function automatic void queue_string();
    int unsigned len;
    int unsigned kind;
    logic [15:0] hi;
    logic [15:0] lo;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        queue_unit(16'($urandom_range(1, 'h7F)), 1'b0);
      end else if (kind < 9) begin
        queue_unit(16'($urandom_range('h80, 'h7FF)), 1'b0);
      end else if (kind < 12) begin
        if ($urandom_range(0, 1) == 0) queue_unit(16'($urandom_range('h800, 'hD7FF)), 1'b0);
        else queue_unit(16'($urandom_range('hE000, 'hFFFF)), 1'b0);
      end else if (kind < 16) begin
        hi = 16'($urandom_range(SURR_MIN, LOW_HALF_MIN - 1));
        lo = 16'($urandom_range(LOW_HALF_MIN, SURR_MAX));
        // Swapped order now and then: low half first.
        if ($urandom_range(0, 3) == 0) begin
          queue_unit(lo, 1'b0);
          queue_unit(hi, 1'b0);
        end else begin
          queue_unit(hi, 1'b0);
          queue_unit(lo, 1'b0);
        end
      end else if (kind < 17) begin
        queue_unit(16'($urandom_range(SURR_MIN, SURR_MAX)), 1'b0);
      end else if (kind < 18) begin
        queue_unit('0, 1'b0);
      end else begin
        queue_unit(16'($urandom_range(0, 'hFFFF)), 1'b0);
      end
    end
    kind = $urandom_range(0, 7);
    if (kind == 0) queue_unit('0, 1'b1);
    else if (kind == 1) queue_unit(16'($urandom_range(SURR_MIN, SURR_MAX)), 1'b1);
    else if (kind == 2) queue_unit(16'($urandom_range(0, 'hFFFF)), 1'b1);
    else queue_unit(16'($urandom_range(1, 'h7FF)), 1'b1);
  endfunction

  // Offer one transaction, keeping valid high inside a burst; insert a random
  // gap when a burst runs out.
  task automatic send_unit(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data  <= in_item_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predictor.note_unit(it);
  endtask

  // Drop valid and wait until every expected byte has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  // Write the capacity register; only called with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    predictor.capacity = value;
    @(posedge clk);
  endtask

  // Send everything queued; optionally request the long hold-off or pause the
  // sender until the result stream is empty at a given transaction index.
  task automatic run_units(input int hold_at, input int pause_at);
    in_item_t u;
    int       idx;
    idx = 0;
    while (stim_units.size() != 0) begin
      if (idx == hold_at) hold_req = 1'b1;
      if (idx == pause_at) drain();
      u = stim_units.pop_front();
      send_unit(u);
      idx++;
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[7];
    predictor   = new();
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity: byte-length boundaries, pairs in
    // both orders, partner taken whatever its value, lone surrogate on the
    // final unit, zero unit ending the string and the units dropped after it.
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    queue_unit(SURR_MIN, 1'b0);
    queue_unit(LOW_HALF_MIN, 1'b0);
    queue_unit(LOW_HALF_MIN - 16'd1, 1'b0);
    queue_unit(SURR_MAX, 1'b0);
    queue_unit(LOW_HALF_MIN, 1'b0);
    queue_unit(SURR_MIN, 1'b0);
    queue_unit(16'hD83D, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'hDABC, 1'b0);
    queue_unit(16'h0042, 1'b0);
    queue_unit(16'h00E9, 1'b1);
    queue_unit(16'hDDDD, 1'b1);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h0043, 1'b0);
    queue_unit(SURR_MIN, 1'b1);
    run_units(-1, -1);
    drain();

    // Capacity stop: a three-byte and a four-byte character that do not fit.
    write_capacity(16'd4);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h0042, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'h0044, 1'b1);
    queue_unit(SURR_MIN, 1'b0);
    queue_unit(LOW_HALF_MIN, 1'b1);
    run_units(-1, -1);
    drain();

    // Smallest capacity: nothing fits, only the terminator comes out.
    write_capacity(16'd1);
    queue_unit(16'h0041, 1'b1);
    run_units(-1, -1);
    drain();

    // Random phases over a spread of capacities, extremes included.
    caps[0] = 16'hFFFF;
    caps[1] = 16'd1;
    caps[2] = 16'd2;
    caps[3] = CAP_W'($urandom_range(3, 12));
    caps[4] = CAP_W'($urandom_range(13, 80));
    caps[5] = CAP_RESET;
    caps[6] = CAP_W'($urandom_range(1, 'hFFFF));
    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      while (stim_units.size() < PHASE_UNITS) queue_string();
      // Long receiver hold-off while the sender keeps offering in the wide
      // open phase; a mid-phase sender pause in another one.
      run_units((p == 0) ? 10 : -1, (p == 3) ? PHASE_UNITS / 2 : -1);
      drain();
    end

    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== utf16_to_utf8_transcoder.f =====
hdl/utt_pkg.sv
hdl/utt_front.sv
hdl/utt_queue.sv
hdl/utt_back.sv
hdl/utf16_to_utf8_transcoder.sv
tb/sv/utf8_byte_predictor_pkg.sv
tb/sv/tb_utf16_to_utf8_transcoder.sv
